### hdl/ssr_pkg.sv
// shared types and constants for the shamir secret recovery unit
// no dependencies
package ssr_pkg;

    localparam int DW = 16;
    localparam logic [DW-1:0] MODULUS_RESET = 16'd65521;
    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [DW-1:0] share_id;
        logic [DW-1:0] share_value;
        logic          last_share;
    } share_req_t;

    typedef struct packed {
        logic [DW-1:0] secret;
        logic          status;
    } result_t;

    typedef enum logic {
        AOP_DIV,
        AOP_MUL
    } aop_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_STORE,
        CMD_INIT,
        CMD_RD_XI,
        CMD_RED_X,
        CMD_SET_XI,
        CMD_RD_XJ,
        CMD_SET_XJ,
        CMD_NEXT_J,
        CMD_MUL_NUM,
        CMD_SET_NUM,
        CMD_MUL_DEN,
        CMD_SET_DEN,
        CMD_EUC_INIT,
        CMD_EUC_DIV,
        CMD_EUC_Q,
        CMD_EUC_MUL,
        CMD_EUC_STEP,
        CMD_MUL_INV,
        CMD_RD_Y,
        CMD_SET_Y,
        CMD_MUL_Y,
        CMD_ACC,
        CMD_OUT_OK,
        CMD_OUT_ERR
    } cmd_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_RD_XI,
        S_RED_XI,
        S_W_XI,
        S_J_TEST,
        S_RD_XJ,
        S_RED_XJ,
        S_W_XJ,
        S_MUL_NUM,
        S_W_NUM,
        S_MUL_DEN,
        S_W_DEN,
        S_EUC_INIT,
        S_EUC_TEST,
        S_EUC_DIV,
        S_W_EDIV,
        S_EUC_MUL,
        S_W_EMUL,
        S_MUL_INV,
        S_W_INV,
        S_RD_Y,
        S_RED_Y,
        S_W_Y,
        S_MUL_Y,
        S_W_MUL_Y,
        S_DONE,
        S_FAIL
    } state_t;

    typedef struct packed {
        logic done;
        logic mod_small;
        logic j_eq_i;
        logic j_last;
        logic i_last;
        logic r1_zero;
        logic r0_one;
        logic out_busy;
    } dp_status_t;

endpackage

### hdl/ssr_arith.sv
// bit-serial divider and modular multiplier, one bit per cycle
// depends on ssr_pkg
module ssr_arith (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ssr_pkg::aop_t        op,
    input  logic [ssr_pkg::DW-1:0] a,
    input  logic [ssr_pkg::DW-1:0] b,
    input  logic [ssr_pkg::DW-1:0] m,
    output logic                 done,
    output logic                 busy,
    output logic [ssr_pkg::DW-1:0] quo,
    output logic [ssr_pkg::DW-1:0] rem
);
    import ssr_pkg::*;

    localparam int CNTW = $clog2(DW);

    logic                busy_reg;
    logic                done_reg;
    aop_t                op_reg;
    logic [CNTW-1:0]     cnt_reg;
    logic [DW-1:0]       a_reg;
    logic [DW-1:0]       b_reg;
    logic [DW-1:0]       m_reg;
    logic [DW-1:0]       acc_reg;
    logic [DW-1:0]       q_reg;

    logic [DW:0]         div_sh;
    logic                div_bit;
    logic [DW-1:0]       div_next;
    logic [DW:0]         dbl;
    logic [DW-1:0]       dbl_r;
    logic [DW:0]         add;
    logic [DW-1:0]       add_r;
    logic [DW-1:0]       acc_next;

    always_comb
    begin
        div_sh   = {acc_reg, a_reg[DW-1]};
        div_bit  = (div_sh >= {1'b0, m_reg});
        div_next = div_bit ? DW'(div_sh - {1'b0, m_reg}) : div_sh[DW-1:0];
        dbl      = {acc_reg, 1'b0};
        dbl_r    = (dbl >= {1'b0, m_reg}) ? DW'(dbl - {1'b0, m_reg}) : dbl[DW-1:0];
        add      = {1'b0, dbl_r} + {1'b0, b_reg};
        add_r    = (add >= {1'b0, m_reg}) ? DW'(add - {1'b0, m_reg}) : add[DW-1:0];
        if (op_reg == AOP_DIV)
        begin
            acc_next = div_next;
        end
        else
        begin
            acc_next = a_reg[DW-1] ? add_r : dbl_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg  <= op;
            a_reg   <= a;
            b_reg   <= b;
            m_reg   <= m;
            acc_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            a_reg   <= {a_reg[DW-2:0], 1'b0};
            q_reg   <= {q_reg[DW-2:0], div_bit};
        end
    end

    assign done = done_reg;
    assign busy = busy_reg;
    assign quo  = q_reg;
    assign rem  = acc_reg;

endmodule

### hdl/ssr_dpath.sv
// share store, recovery registers and result register
// depends on ssr_pkg and ssr_arith
module ssr_dpath #(
    parameter int MAX_SHARES = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ssr_pkg::cmd_t        cmd,
    output ssr_pkg::dp_status_t  status,
    input  ssr_pkg::share_req_t  req,
    input  logic                 cfg_valid,
    input  logic [ssr_pkg::DW-1:0] cfg_data,
    output logic                 result_valid,
    input  logic                 result_ready,
    output ssr_pkg::result_t     result
);
    import ssr_pkg::*;

    localparam int IW = $clog2(MAX_SHARES);
    localparam int CW = $clog2(MAX_SHARES + 1);

    logic [DW-1:0] id_mem  [MAX_SHARES];
    logic [DW-1:0] val_mem [MAX_SHARES];

    logic [DW-1:0] modulus_reg;
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] i_reg;
    logic [IW-1:0] j_reg;
    logic [DW-1:0] n_reg;
    logic [DW-1:0] rdq_reg;
    logic [DW-1:0] xi_reg;
    logic [DW-1:0] xj_reg;
    logic [DW-1:0] y_reg;
    logic [DW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] r0_reg;
    logic [DW-1:0] r1_reg;
    logic [DW-1:0] r2_reg;
    logic [DW-1:0] t0_reg;
    logic [DW-1:0] t1_reg;
    logic [DW-1:0] q_reg;
    logic [DW-1:0] sum_reg;
    logic          out_valid_reg;
    result_t       out_reg;

    logic          a_start;
    aop_t          a_op;
    logic [DW-1:0] a_a;
    logic [DW-1:0] a_b;
    logic [DW-1:0] a_m;
    logic          a_done;
    logic          a_busy;
    logic [DW-1:0] a_quo;
    logic [DW-1:0] a_rem;

    logic [DW-1:0] nx;
    logic [DW-1:0] dx;
    logic [DW-1:0] t2;
    logic [DW:0]   sum_w;
    logic [DW-1:0] sum_next;
    logic          rd_val;
    logic [IW-1:0] rd_addr;

    ssr_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .start (a_start),
        .op    (a_op),
        .a     (a_a),
        .b     (a_b),
        .m     (a_m),
        .done  (a_done),
        .busy  (a_busy),
        .quo   (a_quo),
        .rem   (a_rem)
    );

    always_comb
    begin
        nx       = (xj_reg == '0) ? '0 : DW'(n_reg - xj_reg);
        dx       = (xi_reg >= xj_reg) ? DW'(xi_reg - xj_reg) : DW'(xi_reg + n_reg - xj_reg);
        t2       = (t0_reg >= a_rem) ? DW'(t0_reg - a_rem) : DW'(t0_reg + n_reg - a_rem);
        sum_w    = {1'b0, sum_reg} + {1'b0, a_rem};
        sum_next = (sum_w >= {1'b0, n_reg}) ? DW'(sum_w - {1'b0, n_reg}) : sum_w[DW-1:0];
        rd_val   = (cmd == CMD_RD_Y);
        rd_addr  = (cmd == CMD_RD_XJ) ? j_reg : i_reg;
    end

    always_comb
    begin
        a_start = 1'b1;
        a_op    = AOP_MUL;
        a_a     = num_reg;
        a_b     = '0;
        a_m     = n_reg;
        case (cmd)
            CMD_RED_X:
            begin
                a_op = AOP_DIV;
                a_a  = rdq_reg;
            end
            CMD_MUL_NUM: a_b = nx;
            CMD_MUL_DEN:
            begin
                a_a = den_reg;
                a_b = dx;
            end
            CMD_EUC_DIV:
            begin
                a_op = AOP_DIV;
                a_a  = r0_reg;
                a_m  = r1_reg;
            end
            CMD_EUC_MUL:
            begin
                a_a = q_reg;
                a_b = t1_reg;
            end
            CMD_MUL_INV: a_b = t0_reg;
            CMD_MUL_Y:   a_b = y_reg;
            default:     a_start = 1'b0;
        endcase
    end

    // share store
    always_ff @(posedge clk)
    begin
        if (cmd == CMD_STORE && cnt_reg < CW'(MAX_SHARES))
        begin
            id_mem[cnt_reg[IW-1:0]]  <= req.share_id;
            val_mem[cnt_reg[IW-1:0]] <= req.share_value;
        end
        rdq_reg <= rd_val ? val_mem[rd_addr] : id_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= MODULUS_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                modulus_reg <= cfg_data;
            end
            if (result_valid && result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd)
                CMD_STORE:
                begin
                    if (cnt_reg < CW'(MAX_SHARES))
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                CMD_OUT_OK, CMD_OUT_ERR:
                begin
                    cnt_reg       <= '0;
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_INIT:
            begin
                n_reg   <= modulus_reg;
                i_reg   <= '0;
                sum_reg <= '0;
            end
            CMD_SET_XI:
            begin
                xi_reg  <= a_rem;
                num_reg <= DW'(1);
                den_reg <= DW'(1);
                j_reg   <= '0;
            end
            CMD_SET_XJ:  xj_reg  <= a_rem;
            CMD_NEXT_J:  j_reg   <= j_reg + IW'(1);
            CMD_SET_NUM: num_reg <= a_rem;
            CMD_SET_DEN:
            begin
                den_reg <= a_rem;
                j_reg   <= j_reg + IW'(1);
            end
            CMD_EUC_INIT:
            begin
                r0_reg <= n_reg;
                r1_reg <= den_reg;
                t0_reg <= '0;
                t1_reg <= DW'(1);
            end
            CMD_EUC_Q:
            begin
                q_reg  <= a_quo;
                r2_reg <= a_rem;
            end
            CMD_EUC_STEP:
            begin
                r0_reg <= r1_reg;
                r1_reg <= r2_reg;
                t0_reg <= t1_reg;
                t1_reg <= t2;
            end
            CMD_SET_Y:   y_reg <= a_rem;
            CMD_ACC:
            begin
                sum_reg <= sum_next;
                i_reg   <= i_reg + IW'(1);
            end
            CMD_OUT_OK:
            begin
                out_reg.secret <= sum_reg;
                out_reg.status <= STATUS_OK;
            end
            CMD_OUT_ERR:
            begin
                out_reg.secret <= '0;
                out_reg.status <= STATUS_ERR;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        status.done      = a_done;
        status.mod_small = (modulus_reg < DW'(2));
        status.j_eq_i    = (j_reg == i_reg);
        status.j_last    = (CW'(j_reg) == cnt_reg - CW'(1));
        status.i_last    = (CW'(i_reg) == cnt_reg - CW'(1));
        status.r1_zero   = (r1_reg == '0);
        status.r0_one    = (r0_reg == DW'(1));
        status.out_busy  = out_valid_reg;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_SHARES))
        else $error("share count beyond capacity");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        a_start |-> !a_busy)
        else $error("arithmetic unit started while busy");
    a_ok_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_OUT_OK |=> out_reg.secret < n_reg)
        else $error("secret not reduced");
    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> cnt_reg == '0)
        else $error("share set not emptied on result");
`endif

endmodule

### hdl/ssr_ctrl.sv
// recovery sequencer issuing datapath commands
// depends on ssr_pkg
module ssr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                last_share,
    output logic                req_ready,
    output ssr_pkg::cmd_t       cmd,
    input  ssr_pkg::dp_status_t status
);
    import ssr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd = CMD_STORE;
                    if (last_share)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                cmd        = CMD_INIT;
                state_next = status.mod_small ? S_FAIL : S_RD_XI;
            end
            S_RD_XI:
            begin
                cmd        = CMD_RD_XI;
                state_next = S_RED_XI;
            end
            S_RED_XI:
            begin
                cmd        = CMD_RED_X;
                state_next = S_W_XI;
            end
            S_W_XI:
            begin
                if (status.done)
                begin
                    cmd        = CMD_SET_XI;
                    state_next = S_J_TEST;
                end
            end
            S_J_TEST:
            begin
                if (status.j_eq_i)
                begin
                    cmd        = CMD_NEXT_J;
                    state_next = status.j_last ? S_EUC_INIT : S_J_TEST;
                end
                else
                begin
                    state_next = S_RD_XJ;
                end
            end
            S_RD_XJ:
            begin
                cmd        = CMD_RD_XJ;
                state_next = S_RED_XJ;
            end
            S_RED_XJ:
            begin
                cmd        = CMD_RED_X;
                state_next = S_W_XJ;
            end
            S_W_XJ:
            begin
                if (status.done)
                begin
                    cmd        = CMD_SET_XJ;
                    state_next = S_MUL_NUM;
                end
            end
            S_MUL_NUM:
            begin
                cmd        = CMD_MUL_NUM;
                state_next = S_W_NUM;
            end
            S_W_NUM:
            begin
                if (status.done)
                begin
                    cmd        = CMD_SET_NUM;
                    state_next = S_MUL_DEN;
                end
            end
            S_MUL_DEN:
            begin
                cmd        = CMD_MUL_DEN;
                state_next = S_W_DEN;
            end
            S_W_DEN:
            begin
                if (status.done)
                begin
                    cmd        = CMD_SET_DEN;
                    state_next = status.j_last ? S_EUC_INIT : S_J_TEST;
                end
            end
            S_EUC_INIT:
            begin
                cmd        = CMD_EUC_INIT;
                state_next = S_EUC_TEST;
            end
            S_EUC_TEST:
            begin
                if (status.r1_zero)
                begin
                    state_next = status.r0_one ? S_MUL_INV : S_FAIL;
                end
                else
                begin
                    state_next = S_EUC_DIV;
                end
            end
            S_EUC_DIV:
            begin
                cmd        = CMD_EUC_DIV;
                state_next = S_W_EDIV;
            end
            S_W_EDIV:
            begin
                if (status.done)
                begin
                    cmd        = CMD_EUC_Q;
                    state_next = S_EUC_MUL;
                end
            end
            S_EUC_MUL:
            begin
                cmd        = CMD_EUC_MUL;
                state_next = S_W_EMUL;
            end
            S_W_EMUL:
            begin
                if (status.done)
                begin
                    cmd        = CMD_EUC_STEP;
                    state_next = S_EUC_TEST;
                end
            end
            S_MUL_INV:
            begin
                cmd        = CMD_MUL_INV;
                state_next = S_W_INV;
            end
            S_W_INV:
            begin
                if (status.done)
                begin
                    cmd        = CMD_SET_NUM;
                    state_next = S_RD_Y;
                end
            end
            S_RD_Y:
            begin
                cmd        = CMD_RD_Y;
                state_next = S_RED_Y;
            end
            S_RED_Y:
            begin
                cmd        = CMD_RED_X;
                state_next = S_W_Y;
            end
            S_W_Y:
            begin
                if (status.done)
                begin
                    cmd        = CMD_SET_Y;
                    state_next = S_MUL_Y;
                end
            end
            S_MUL_Y:
            begin
                cmd        = CMD_MUL_Y;
                state_next = S_W_MUL_Y;
            end
            S_W_MUL_Y:
            begin
                if (status.done)
                begin
                    cmd        = CMD_ACC;
                    state_next = status.i_last ? S_DONE : S_RD_XI;
                end
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd        = CMD_OUT_OK;
                    state_next = S_IDLE;
                end
            end
            S_FAIL:
            begin
                if (!status.out_busy)
                begin
                    cmd        = CMD_OUT_ERR;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/shamir_secret_recovery_unit.sv
// top level of the shamir secret recovery unit
// depends on ssr_pkg, ssr_ctrl, ssr_dpath
//
// channel   signals                            payload
// req       req_valid / req_ready / req        share_req_t
// result    result_valid / result_ready / result  result_t
// cfg       cfg_valid / cfg_ready / cfg_data   modulus, always ready
//
// an unmarked share is only stored; a marked share is stored and starts recovery
// recovery runs a euclid inversion for each share, with every step on the
// one bit-per-cycle divider/multiplier
// no new request is taken during recovery; a waiting result does not block storing
// reset clears the share count and the result valid flag, modulus resets to 65521
module shamir_secret_recovery_unit #(
    parameter int MAX_SHARES = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  ssr_pkg::share_req_t  req,
    output logic                 result_valid,
    input  logic                 result_ready,
    output ssr_pkg::result_t     result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [ssr_pkg::DW-1:0] cfg_data
);
    import ssr_pkg::*;

    cmd_t       cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    ssr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .last_share (req.last_share),
        .req_ready  (req_ready),
        .cmd        (cmd),
        .status     (status)
    );

    ssr_dpath #(
        .MAX_SHARES (MAX_SHARES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .req          (req),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
